// File: src/hrxd_pkg.sv
// ----------------------------------------------------------------------------
// hrxd_pkg
// Shared types and constants of the Huffman, run-length and line-XOR picture
// decoder.
// ----------------------------------------------------------------------------
package hrxd_pkg;

    localparam int TREE_BYTES = 256;
    localparam int GROUP_BITS = 64;
    localparam int COUNT_W    = 5;
    localparam int LW_W       = 11;

    localparam logic [7:0] TERMINAL_MIN = 8'd128;
    localparam logic [7:0] COLOR_LIMIT  = 8'd16;
    localparam logic [7:0] RUN_BIAS     = 8'd15;

    localparam logic [1:0] KIND_TREE  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    typedef enum logic [1:0] {
        OP_TREE,
        OP_START,
        OP_DATA
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [15:0] count;
        logic        last;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TREQ,
        S_TRESP,
        S_BITNEXT,
        S_PREAD,
        S_PWRITE,
        S_SYMEND,
        S_FINISH
    } state_t;

endpackage

// File: src/huffman_rle_xor_picture_decoder_core.sv
// ----------------------------------------------------------------------------
// huffman_rle_xor_picture_decoder_core
// Picture decoder with optional Huffman tree walk, run expansion and
// previous-line XOR, packing pixels into groups.
// ----------------------------------------------------------------------------
// A Huffman data byte leaves the queue, then walks the tree bit by bit (tree RAM
// request, response, next bit); each symbol found adds an end-of-symbol step and
// each pixel a line RAM read, then XOR and write back. A raw byte goes straight to
// its pixels and end-of-symbol step; a picture end adds a finish step, and output
// stalls hold the engine. Reset clears the state, position and packing registers,
// not the per-symbol or output data ones; the line store needs no clearing pass.
module huffman_rle_xor_picture_decoder_core #(
    parameter int LINE_MAX         = 1024,
    parameter int PIXELS_PER_GROUP = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  tree_index,
    input  logic [7:0]  tree_value,
    input  logic [15:0] symbol_count,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] pixel_group,
    output logic [4:0]  pixel_count,
    output logic        last_group
);

    logic                        huff_reg;
    logic [hrxd_pkg::LW_W-1:0]   lw_reg;
    logic                        q_valid;
    logic                        q_pop;
    hrxd_pkg::entry_t            q_entry;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {21'd0, lw_reg} : {31'd0, huff_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            huff_reg <= 1'b1;
            lw_reg   <= 11'd320;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
            begin
                lw_reg <= pwdata[hrxd_pkg::LW_W-1:0];
            end
            else
            begin
                huff_reg <= pwdata[0];
            end
        end
    end

    hrxd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .tree_index   (tree_index),
        .tree_value   (tree_value),
        .symbol_count (symbol_count),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    hrxd_back #(
        .LINE_MAX         (LINE_MAX),
        .PIXELS_PER_GROUP (PIXELS_PER_GROUP)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .huffman_enable (huff_reg),
        .line_width     (lw_reg),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_group    (pixel_group),
        .pixel_count    (pixel_count),
        .last_group     (last_group)
    );

endmodule

// File: src/hrxd_ram.sv
// ----------------------------------------------------------------------------
// hrxd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrxd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/hrxd_front.sv
// ----------------------------------------------------------------------------
// hrxd_front
// Accepts input transfers, classifies them by kind and queues them for the
// decoding engine. Unknown kinds are accepted and dropped.
// ----------------------------------------------------------------------------
module hrxd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [7:0]         tree_index,
    input  logic [7:0]         tree_value,
    input  logic [15:0]        symbol_count,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               q_valid,
    output hrxd_pkg::entry_t   q_entry,
    input  logic               q_pop
);

    localparam int QD = 4;
    localparam int QA = $clog2(QD);

    hrxd_pkg::entry_t q_mem_reg [QD];
    logic [QA-1:0]    wr_ptr_reg;
    logic [QA-1:0]    rd_ptr_reg;
    logic [QA:0]      cnt_reg;
    logic             push;
    logic             pop;
    hrxd_pkg::entry_t new_entry;

    assign in_stall = (cnt_reg == (QA+1)'(QD));
    assign q_valid  = (cnt_reg != '0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        new_entry.op     = hrxd_pkg::OP_DATA;
        new_entry.byte_a = tree_index;
        new_entry.byte_b = data_byte;
        new_entry.count  = symbol_count;
        new_entry.last   = last_byte;
        push             = 1'b0;
        unique case (kind)
            hrxd_pkg::KIND_TREE:
            begin
                new_entry.op     = hrxd_pkg::OP_TREE;
                new_entry.byte_b = tree_value;
                push             = in_valid && !in_stall;
            end
            hrxd_pkg::KIND_START:
            begin
                new_entry.op = hrxd_pkg::OP_START;
                push         = in_valid && !in_stall;
            end
            hrxd_pkg::KIND_DATA:
            begin
                push = in_valid && !in_stall;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QA'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QA'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (QA+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (QA+1)'(1);
            end
        end
    end

endmodule

// File: src/hrxd_back.sv
// ----------------------------------------------------------------------------
// hrxd_back
// Decoding engine: tree walk one bit at a time, run expansion, line XOR
// through the line store and packing of pixels into output groups.
// ----------------------------------------------------------------------------
module hrxd_back #(
    parameter int LINE_MAX         = 1024,
    parameter int PIXELS_PER_GROUP = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           huffman_enable,
    input  logic [hrxd_pkg::LW_W-1:0]      line_width,
    input  logic                           q_valid,
    input  hrxd_pkg::entry_t               q_entry,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hrxd_pkg::GROUP_BITS-1:0] pixel_group,
    output logic [hrxd_pkg::COUNT_W-1:0]   pixel_count,
    output logic                           last_group
);

    localparam int POS_W = $clog2(LINE_MAX);
    localparam int CW    = (POS_W + 1 > hrxd_pkg::LW_W) ? POS_W + 1 : hrxd_pkg::LW_W;
    localparam logic [hrxd_pkg::COUNT_W-1:0] PPG = hrxd_pkg::COUNT_W'(PIXELS_PER_GROUP);

    hrxd_pkg::state_t state_reg, state_next;
    logic [7:0]  node_reg, node_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic        from_tree_reg, from_tree_next;
    logic [15:0] left_reg, left_next;
    logic [3:0]  color_reg, color_next;
    logic [7:0]  run_reg, run_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W:0]   fill_reg, fill_next;
    logic [hrxd_pkg::GROUP_BITS-1:0] pack_reg, pack_next;
    logic [hrxd_pkg::COUNT_W-1:0]    pfill_reg, pfill_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    logic [hrxd_pkg::GROUP_BITS-1:0] group_reg, group_next;
    logic [hrxd_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic        lastg_reg, lastg_next;

    logic                 tree_we;
    logic [7:0]           tree_waddr, tree_wdata, tree_raddr, tree_rdata;
    logic                 line_we;
    logic [POS_W-1:0]     line_raddr;
    logic [3:0]           line_wdata, line_rdata;
    logic [CW-1:0]        eff_w;
    logic [POS_W-1:0]     pos_eff;
    logic [CW-1:0]        pos_inc;
    logic [3:0]           pix;
    logic                 out_free;
    logic [7:0]           sym;
    logic                 sym_go;

    hrxd_ram #(.WIDTH(8), .DEPTH(hrxd_pkg::TREE_BYTES)) u_tree_ram (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (tree_rdata)
    );

    hrxd_ram #(.WIDTH(4), .DEPTH(LINE_MAX)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (pos_reg),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    always_comb
    begin
        if (line_width == '0)
        begin
            eff_w = CW'(1);
        end
        else if (CW'(line_width) > CW'(LINE_MAX))
        begin
            eff_w = CW'(LINE_MAX);
        end
        else
        begin
            eff_w = CW'(line_width);
        end
    end

    assign pos_eff    = (CW'(pos_reg) >= eff_w) ? '0 : pos_reg;
    assign pos_inc    = CW'(pos_reg) + CW'(1);
    assign line_raddr = (state_reg == hrxd_pkg::S_PREAD) ? pos_eff : pos_reg;
    assign tree_raddr = node_reg + {7'd0, data_reg[bit_reg]};
    assign out_free   = !out_valid_reg || !out_stall;
    assign pix        = color_reg ^ (({1'b0, pos_reg} < fill_reg) ? line_rdata : 4'd0);
    assign line_wdata = pix;

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        bit_next       = bit_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        from_tree_next = from_tree_reg;
        left_next      = left_reg;
        color_next     = color_reg;
        run_next       = run_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        pack_next      = pack_reg;
        pfill_next     = pfill_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && out_stall;
        group_next     = group_reg;
        count_next     = count_reg;
        lastg_next     = lastg_reg;
        q_pop          = 1'b0;
        tree_we        = 1'b0;
        tree_waddr     = q_entry.byte_a;
        tree_wdata     = q_entry.byte_b;
        line_we        = 1'b0;
        sym            = q_entry.byte_b;
        sym_go         = 1'b0;

        unique case (state_reg)
            hrxd_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.op)
                        hrxd_pkg::OP_TREE:
                        begin
                            tree_we = 1'b1;
                        end
                        hrxd_pkg::OP_START:
                        begin
                            pos_next   = '0;
                            fill_next  = '0;
                            node_next  = '0;
                            color_next = '0;
                            left_next  = q_entry.count;
                            pack_next  = '0;
                            pfill_next = '0;
                            done_next  = 1'b0;
                        end
                        hrxd_pkg::OP_DATA:
                        begin
                            if (!done_reg)
                            begin
                                data_next = q_entry.byte_b;
                                last_next = q_entry.last;
                                if (huffman_enable)
                                begin
                                    bit_next   = 3'd7;
                                    state_next = hrxd_pkg::S_TREQ;
                                end
                                else
                                begin
                                    from_tree_next = 1'b0;
                                    sym            = q_entry.byte_b;
                                    sym_go         = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            hrxd_pkg::S_TREQ:
            begin
                state_next = hrxd_pkg::S_TRESP;
            end
            hrxd_pkg::S_TRESP:
            begin
                if (tree_rdata < hrxd_pkg::TERMINAL_MIN)
                begin
                    node_next  = {tree_rdata[6:0], 1'b0};
                    state_next = hrxd_pkg::S_BITNEXT;
                end
                else
                begin
                    node_next      = '0;
                    from_tree_next = 1'b1;
                    sym            = {1'b0, tree_rdata[6:0]};
                    sym_go         = 1'b1;
                end
            end
            hrxd_pkg::S_BITNEXT:
            begin
                if (bit_reg == 3'd0)
                begin
                    state_next = last_reg ? hrxd_pkg::S_FINISH : hrxd_pkg::S_IDLE;
                end
                else
                begin
                    bit_next   = bit_reg - 3'd1;
                    state_next = hrxd_pkg::S_TREQ;
                end
            end
            hrxd_pkg::S_PREAD:
            begin
                pos_next   = pos_eff;
                state_next = hrxd_pkg::S_PWRITE;
            end
            hrxd_pkg::S_PWRITE:
            begin
                if (!(pfill_reg == PPG && !out_free))
                begin
                    line_we = 1'b1;
                    if ({1'b0, pos_reg} >= fill_reg)
                    begin
                        fill_next = pos_inc[POS_W:0];
                    end
                    pos_next = (pos_inc >= eff_w) ? '0 : pos_inc[POS_W-1:0];
                    if (pfill_reg == PPG)
                    begin
                        out_valid_next = 1'b1;
                        group_next     = pack_reg;
                        count_next     = pfill_reg;
                        lastg_next     = 1'b0;
                        pack_next      = {{(hrxd_pkg::GROUP_BITS-4){1'b0}}, pix};
                        pfill_next     = hrxd_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        for (int k = 0; k < PIXELS_PER_GROUP; k++)
                        begin
                            if (pfill_reg == hrxd_pkg::COUNT_W'(k))
                            begin
                                pack_next[4*k +: 4] = pix;
                            end
                        end
                        pfill_next = pfill_reg + hrxd_pkg::COUNT_W'(1);
                    end
                    run_next   = run_reg - 8'd1;
                    state_next = (run_reg == 8'd1) ? hrxd_pkg::S_SYMEND
                                                   : hrxd_pkg::S_PREAD;
                end
            end
            hrxd_pkg::S_SYMEND:
            begin
                if (!from_tree_reg)
                begin
                    state_next = last_reg ? hrxd_pkg::S_FINISH : hrxd_pkg::S_IDLE;
                end
                else if (left_reg <= 16'd1)
                begin
                    left_next  = '0;
                    state_next = hrxd_pkg::S_FINISH;
                end
                else
                begin
                    left_next  = left_reg - 16'd1;
                    state_next = hrxd_pkg::S_BITNEXT;
                end
            end
            hrxd_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    group_next     = pack_reg;
                    count_next     = pfill_reg;
                    lastg_next     = 1'b1;
                    pack_next      = '0;
                    pfill_next     = '0;
                    done_next      = 1'b1;
                    node_next      = '0;
                    state_next     = hrxd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hrxd_pkg::S_IDLE;
            end
        endcase

        if (sym_go)
        begin
            if (sym < hrxd_pkg::COLOR_LIMIT)
            begin
                color_next = sym[3:0];
                run_next   = 8'd1;
            end
            else
            begin
                run_next = sym - hrxd_pkg::RUN_BIAS;
            end
            state_next = hrxd_pkg::S_PREAD;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg       <= bit_next;
        data_reg      <= data_next;
        last_reg      <= last_next;
        from_tree_reg <= from_tree_next;
        run_reg       <= run_next;
        group_reg     <= group_next;
        count_reg     <= count_next;
        lastg_reg     <= lastg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrxd_pkg::S_IDLE;
            node_reg      <= '0;
            left_reg      <= '0;
            color_reg     <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            pack_reg      <= '0;
            pfill_reg     <= '0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            left_reg      <= left_next;
            color_reg     <= color_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            pack_reg      <= pack_next;
            pfill_reg     <= pfill_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_group = group_reg;
    assign pixel_count = count_reg;
    assign last_group  = lastg_reg;

endmodule

// File: src/hrxd_checker.sv
// ----------------------------------------------------------------------------
// hrxd_checker
// Port-level checks of the picture decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hrxd_checker #(
    parameter int PIXELS_PER_GROUP = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] pixel_group,
    input logic [4:0]  pixel_count,
    input logic        last_group
);

    localparam logic [4:0] PPG = 5'(PIXELS_PER_GROUP);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_group))
        else $error("Stalled output transfer was dropped or changed.");

    a_full_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_group |-> pixel_count == PPG)
        else $error("A group other than the last one is not full.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_group |-> pixel_count <= PPG)
        else $error("Final group reports too many pixels.");

endmodule

bind huffman_rle_xor_picture_decoder_core hrxd_checker #(
    .PIXELS_PER_GROUP (PIXELS_PER_GROUP)
) u_hrxd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_group (pixel_group),
    .pixel_count (pixel_count),
    .last_group  (last_group)
);

// File: tb/tb_huffman_rle_xor_picture_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_rle_xor_picture_decoder_core
// Drives tree loads, picture starts and compressed bytes into the picture
// decoder, predicts every pixel group in the testbench, and compares each
// output transfer against the oldest predicted group.
// ----------------------------------------------------------------------------
module tb_huffman_rle_xor_picture_decoder_core;

    localparam int LINE_LEN   = 1024;
    localparam int GROUP_PIX  = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_WAIT  = 1000;
    localparam logic [2:0] ADDR_HUFF  = 3'd0;
    localparam logic [2:0] ADDR_WIDTH = 3'd4;

    typedef struct packed {
        logic [63:0] pixels;
        logic [4:0]  count;
        logic        last;
    } group_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  tree_index;
    logic [7:0]  tree_value;
    logic [15:0] symbol_count;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] pixel_group;
    logic [4:0]  pixel_count;
    logic        last_group;

    huffman_rle_xor_picture_decoder_core i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .tree_index(tree_index), .tree_value(tree_value),
        .symbol_count(symbol_count), .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_group(pixel_group),
        .pixel_count(pixel_count), .last_group(last_group)
    );

    logic        huff_on;
    logic [10:0] width_reg;
    logic [7:0]  tree_mem [hrxd_pkg::TREE_BYTES];
    logic [3:0]  line_mem [LINE_LEN];
    int unsigned line_pos;
    logic [7:0]  node;
    logic [3:0]  color;
    logic [15:0] syms_left;
    logic [63:0] pack;
    int unsigned fill;
    logic        done;

    group_t groups_due[$];
    int     mismatches;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     stop_checks;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned line_span();
        if (width_reg == 11'd0)
        begin
            return 1;
        end
        if (int'(width_reg) > LINE_LEN)
        begin
            return LINE_LEN;
        end
        return int'(width_reg);
    endfunction

    function automatic void push_group(input logic is_last);
        group_t g;
        g.pixels = pack;
        g.count  = fill[4:0];
        g.last   = is_last;
        groups_due.push_back(g);
        pack = '0;
        fill = 0;
    endfunction

    function automatic void place_pixel(input logic [3:0] c);
        int unsigned w;
        logic [3:0]  p;
        w = line_span();
        if (line_pos >= w)
        begin
            line_pos = 0;
        end
        p = c ^ line_mem[line_pos];
        line_mem[line_pos] = p;
        line_pos++;
        if (line_pos >= w)
        begin
            line_pos = 0;
        end
        if (fill >= GROUP_PIX)
        begin
            push_group(1'b0);
        end
        pack |= 64'(p) << (4 * fill);
        fill++;
    endfunction

    function automatic void expand_symbol(input logic [7:0] s);
        if (s < hrxd_pkg::COLOR_LIMIT)
        begin
            color = s[3:0];
            place_pixel(color);
        end
        else
        begin
            for (int n = 0; n < int'(s) - int'(hrxd_pkg::RUN_BIAS); n++)
            begin
                place_pixel(color);
            end
        end
    endfunction

    function automatic void end_picture();
        push_group(1'b1);
        done = 1'b1;
        node = '0;
    endfunction

    function automatic void predict_groups(input logic [1:0] k, input logic [7:0] idx,
                                           input logic [7:0] val, input logic [15:0] cnt,
                                           input logic [7:0] b, input logic lst);
        logic [7:0] nxt;
        if (k == hrxd_pkg::KIND_TREE)
        begin
            tree_mem[idx] = val;
            return;
        end
        if (k == hrxd_pkg::KIND_START)
        begin
            foreach (line_mem[i])
            begin
                line_mem[i] = '0;
            end
            line_pos = 0;
            node = '0;
            color = '0;
            syms_left = cnt;
            pack = '0;
            fill = 0;
            done = 1'b0;
            return;
        end
        if (k != hrxd_pkg::KIND_DATA || done)
        begin
            return;
        end
        if (!huff_on)
        begin
            expand_symbol(b);
            if (lst)
            begin
                end_picture();
            end
            return;
        end
        for (int i = 7; i >= 0; i--)
        begin
            nxt = tree_mem[node + 8'(b[i])];
            if (nxt < hrxd_pkg::TERMINAL_MIN)
            begin
                node = {nxt[6:0], 1'b0};
            end
            else
            begin
                expand_symbol(nxt - hrxd_pkg::TERMINAL_MIN);
                node = '0;
                if (syms_left <= 16'd1)
                begin
                    syms_left = '0;
                    end_picture();
                    return;
                end
                syms_left--;
            end
        end
        if (lst)
        begin
            end_picture();
        end
    endfunction

    // The valid line stays high after a transfer until the next call or a drain
    // takes it down, so that items can follow back to back.
    task automatic send_item(input logic [1:0] k, input logic [7:0] idx,
                             input logic [7:0] val, input logic [15:0] cnt,
                             input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        tree_index   <= idx;
        tree_value   <= val;
        symbol_count <= cnt;
        data_byte    <= b;
        last_byte    <= lst;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_groups(k, idx, val, cnt, b, lst);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == ADDR_HUFF)
        begin
            huff_on = d[0];
        end
        else
        begin
            width_reg = d[10:0];
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (groups_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_WAIT) @(negedge clk);
    endtask

    task automatic configure(input logic h, input logic [10:0] w);
        drain();
        write_reg(ADDR_HUFF, {31'd0, h});
        write_reg(ADDR_WIDTH, {21'd0, w});
    endtask

    // Tree with eight leaves: colors 0, 15, 3, 9 and runs of 1, 5, 40, 112 pixels.
    task automatic load_tree();
        logic [7:0] img [14];
        img = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
                8'd128, 8'd143, 8'd131, 8'd137, 8'd144, 8'd148, 8'd183, 8'd255};
        for (int i = 0; i < 14; i++)
        begin
            send_item(hrxd_pkg::KIND_TREE, 8'(i), img[i], 16'd0, 8'd0, 1'b0);
        end
        for (int i = 14; i < hrxd_pkg::TREE_BYTES; i++)
        begin
            if ($urandom_range(49) == 0)
            begin
                send_item(hrxd_pkg::KIND_TREE, 8'(i), 8'($urandom), 16'd0, 8'd0, 1'b0);
            end
        end
    endtask

    task automatic test_directed_raw();
        configure(1'b0, 11'd1);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'h05, 1'b1);
        send_item(hrxd_pkg::KIND_START, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'd20, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'h0F, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'd16, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'hFF, 1'b0);
        send_item(2'd3, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'h0A, 1'b1);
        configure(1'b0, 11'd0);
        send_item(hrxd_pkg::KIND_START, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'h03, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'd31, 1'b1);
        configure(1'b0, 11'd2047);
        send_item(hrxd_pkg::KIND_START, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'h07, 1'b1);
    endtask

    task automatic test_directed_tree();
        configure(1'b1, 11'd3);
        load_tree();
        send_item(hrxd_pkg::KIND_START, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'hFF, 1'b0);
        send_item(hrxd_pkg::KIND_START, 8'd0, 8'd0, 16'hFFFF, 8'd0, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'b001_110_01, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'b0_011_100_1, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'h00, 1'b1);
        send_item(hrxd_pkg::KIND_START, 8'd0, 8'd0, 16'd3, 8'd0, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'b101_111_11, 1'b0);
        send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'b1_000_0000, 1'b0);
    endtask

    // Random items never write the tree, so every walk stays on loaded entries.
    task automatic test_random(input int items, input logic h, input logic [10:0] w);
        configure(h, w);
        if (h)
        begin
            load_tree();
        end
        while (items > 0)
        begin
            send_item(hrxd_pkg::KIND_START, 8'd0, 8'd0, 16'($urandom_range(h ? 40 : 3)),
                      8'd0, 1'b0);
            items--;
            for (int n = $urandom_range(1, 8); n > 0; n--)
            begin
                if ($urandom_range(19) == 0)
                begin
                    send_item(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                              16'($urandom), 8'($urandom), 1'($urandom));
                end
                else if (!h && $urandom_range(3) != 0)
                begin
                    send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0,
                              8'($urandom_range(31)), n == 1 ? 1'b1 : 1'b0);
                end
                else
                begin
                    send_item(hrxd_pkg::KIND_DATA, 8'd0, 8'd0, 16'd0, 8'($urandom),
                              n == 1 ? 1'b1 : 1'b0);
                end
                items--;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || stop_checks)
        begin
            idle_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin : check_output
        group_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (groups_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected group %h", pixel_group);
                end
            end
            else
            begin
                want = groups_due.pop_front();
                if (want.pixels !== pixel_group || want.count !== pixel_count ||
                    want.last !== last_group)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("group mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 want.pixels, want.count, want.last,
                                 pixel_group, pixel_count, last_group);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        kind = '0;
        tree_index = '0;
        tree_value = '0;
        symbol_count = '0;
        data_byte = '0;
        last_byte = 1'b0;
        out_stall = 1'b0;
        mismatches = 0;
        stop_checks = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 66;
        huff_on = 1'b1;
        width_reg = 11'd320;
        foreach (tree_mem[i])
        begin
            tree_mem[i] = '0;
        end
        foreach (line_mem[i])
        begin
            line_mem[i] = '0;
        end
        line_pos = 0;
        node = '0;
        color = '0;
        syms_left = '0;
        pack = '0;
        fill = 0;
        done = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_raw();
        test_directed_tree();
        test_random(15, 1'b1, 11'd1024);
        send_idle_pct = 66;
        recv_idle_pct = 29;
        test_random(15, 1'b0, 11'd5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(15, 1'b1, 11'd17);
        drain();
        stop_checks = 1'b1;
        if (mismatches == 0 && groups_due.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: huffman_rle_xor_picture_decoder_core.f
src/hrxd_pkg.sv
src/hrxd_ram.sv
src/hrxd_front.sv
src/hrxd_back.sv
src/huffman_rle_xor_picture_decoder_core.sv
src/hrxd_checker.sv
tb/tb_huffman_rle_xor_picture_decoder_core.sv
